[hdl/tsd_pkg.sv]
// Shared types and constants for the three-level switch debouncer.
package tsd_pkg;

    // Fixed payload widths
    localparam int RAW_W   = 13;
    localparam int LEVEL_W = 12;
    localparam int MODE_W  = 2;
    localparam int RUN_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Batch geometry: eight readings, averaged by a shift
    localparam int BATCH_SIZE = 8;
    localparam int BATCH_LOG2 = $clog2(BATCH_SIZE);

    // Default converter resolution
    localparam int ADC_BITS_DEF = 12;

    // Full-scale millivolts for the level conversion
    localparam logic [LEVEL_W-1:0] FULL_SCALE_MV = 12'd3600;

    // Debounce run saturates here
    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    // Positions and override codes
    localparam logic [MODE_W-1:0] MODE_BT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_USB    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DONGLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FOLLOW = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USB_THR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DONGLE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE   = 2'd3;

    // Register reset values
    localparam logic [LEVEL_W-1:0] USB_THR_RST    = 12'd900;
    localparam logic [LEVEL_W-1:0] DONGLE_THR_RST = 12'd2600;
    localparam logic [RUN_W-1:0]   DEBOUNCE_RST   = 4'd3;
    localparam logic [MODE_W-1:0]  OVERRIDE_RST   = MODE_FOLLOW;

    // Input beat
    typedef struct packed {
        logic signed [RAW_W-1:0] raw_sample;
        logic                    read_failed;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [MODE_W-1:0]  reported_mode;
        logic [MODE_W-1:0]  switch_mode;
        logic [LEVEL_W-1:0] level_mv;
        logic               seen_high;
        logic               seen_low;
    } t_out;

    // Configuration register set
    typedef struct packed {
        logic [LEVEL_W-1:0] usb_thr;
        logic [LEVEL_W-1:0] dongle_thr;
        logic [RUN_W-1:0]   deb_count;
        logic [MODE_W-1:0]  override_mode;
    } t_cfg;

endpackage

[hdl/tsd_accum.sv]
// Sample clamp and batch accumulator; registers each completed batch sum.
module tsd_accum #(
    parameter int ADC_BITS = tsd_pkg::ADC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  tsd_pkg::t_in                         i_item,
    input  logic                                 i_advance,
    output logic                                 o_last,
    output logic                                 o_valid,
    output logic [ADC_BITS+tsd_pkg::BATCH_LOG2-1:0] o_sum
);
    localparam int SUM_W = ADC_BITS + tsd_pkg::BATCH_LOG2;
    localparam int EXT_W = 17;
    localparam logic [EXT_W-1:0] SAMPLE_MAX = EXT_W'((1 << ADC_BITS) - 1);
    localparam logic [tsd_pkg::BATCH_LOG2-1:0] IDX_LAST =
        tsd_pkg::BATCH_LOG2'(tsd_pkg::BATCH_SIZE - 1);

    logic [SUM_W-1:0]               r_sum, n_sum;
    logic [tsd_pkg::BATCH_LOG2-1:0] r_idx, n_idx;
    logic                           r_valid;
    logic [SUM_W-1:0]               r_bsum;
    logic [EXT_W-1:0]               w_ext;
    logic [EXT_W-1:0]               w_clamp;
    logic                           w_done;

    // Negative reads count as zero, over-range reads saturate
    always_comb begin
        w_ext   = EXT_W'(i_item.raw_sample[tsd_pkg::RAW_W-2:0]);
        if (i_item.raw_sample[tsd_pkg::RAW_W-1]) begin
            w_clamp = '0;
        end else if (w_ext > SAMPLE_MAX) begin
            w_clamp = SAMPLE_MAX;
        end else begin
            w_clamp = w_ext;
        end
    end

    assign o_last = (r_idx == IDX_LAST);
    assign w_done = i_accept && !i_item.read_failed && o_last;

    // Running sum and index
    always_comb begin
        n_sum = r_sum;
        n_idx = r_idx;
        if (i_accept) begin
            if (i_item.read_failed || o_last) begin
                n_sum = '0;
                n_idx = '0;
            end else begin
                n_sum = r_sum + SUM_W'(w_clamp[ADC_BITS-1:0]);
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_sum <= n_sum;
            r_idx <= n_idx;
            if (i_advance) begin
                r_valid <= w_done;
            end
        end
    end

    // Completed batch sum, including the closing beat
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_bsum <= r_sum + SUM_W'(w_clamp[ADC_BITS-1:0]);
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_bsum;

endmodule

[hdl/tsd_scale.sv]
// Batch average to millivolt level: one multiply, registered.
module tsd_scale #(
    parameter int ADC_BITS = tsd_pkg::ADC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_advance,
    input  logic                                    i_valid,
    input  logic [ADC_BITS+tsd_pkg::BATCH_LOG2-1:0] i_sum,
    output logic                                    o_valid,
    output logic [tsd_pkg::LEVEL_W-1:0]             o_level
);
    localparam int PROD_W = ADC_BITS + tsd_pkg::LEVEL_W;

    logic [ADC_BITS-1:0]         w_avg;
    logic [PROD_W-1:0]           w_prod;
    logic                        r_valid;
    logic [tsd_pkg::LEVEL_W-1:0] r_level;

    // Average by shift, then scale to full-scale millivolts
    assign w_avg  = i_sum[ADC_BITS+tsd_pkg::BATCH_LOG2-1:tsd_pkg::BATCH_LOG2];
    assign w_prod = PROD_W'(w_avg) * PROD_W'(tsd_pkg::FULL_SCALE_MV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_valid) begin
            r_level <= w_prod[PROD_W-1:ADC_BITS];
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

[hdl/tsd_debounce.sv]
// Position classify, debounce, sticky flags and the output register.
module tsd_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tsd_pkg::t_cfg               i_cfg,
    input  logic                        i_advance,
    input  logic                        i_valid,
    input  logic [tsd_pkg::LEVEL_W-1:0] i_level,
    output logic                        o_valid,
    output tsd_pkg::t_out               o_item
);
    logic [tsd_pkg::MODE_W-1:0] r_committed, n_committed;
    logic [tsd_pkg::MODE_W-1:0] r_pending, n_pending;
    logic [tsd_pkg::RUN_W-1:0]  r_run, n_run;
    logic [tsd_pkg::RUN_W-1:0]  w_run_inc;
    logic                       r_primed, n_primed;
    logic                       r_seen_high, n_seen_high;
    logic                       r_seen_low, n_seen_low;
    logic [tsd_pkg::MODE_W-1:0] w_pos;
    logic                       w_high;
    logic                       w_load;
    logic                       r_valid;
    tsd_pkg::t_out              r_item, n_item;

    assign w_load = i_advance && i_valid;

    // Dongle threshold is checked first
    assign w_high = (i_level >= i_cfg.dongle_thr);
    always_comb begin
        if (w_high) begin
            w_pos = tsd_pkg::MODE_DONGLE;
        end else if (i_level >= i_cfg.usb_thr) begin
            w_pos = tsd_pkg::MODE_USB;
        end else begin
            w_pos = tsd_pkg::MODE_BT;
        end
    end

    assign w_run_inc = (r_run < tsd_pkg::RUN_MAX) ? r_run + 1'b1 : r_run;

    // Debounce next state
    always_comb begin
        n_committed = r_committed;
        n_pending   = r_pending;
        n_run       = r_run;
        n_primed    = r_primed;
        if (!r_primed) begin
            // first batch commits at once
            n_committed = w_pos;
            n_primed    = 1'b1;
        end else if (w_pos == r_committed) begin
            n_run = '0;
        end else if (w_pos == r_pending) begin
            if (w_run_inc >= i_cfg.deb_count) begin
                n_committed = w_pos;
                n_run       = '0;
            end else begin
                n_run = w_run_inc;
            end
        end else begin
            n_pending = w_pos;
            n_run     = tsd_pkg::RUN_W'(1);
        end
        n_seen_high = r_seen_high | w_high;
        n_seen_low  = r_seen_low | !w_high;
    end

    // Result beat
    always_comb begin
        n_item.reported_mode = (i_cfg.override_mode != tsd_pkg::MODE_FOLLOW) ?
                               i_cfg.override_mode : n_committed;
        n_item.switch_mode   = n_committed;
        n_item.level_mv      = i_level;
        n_item.seen_high     = n_seen_high;
        n_item.seen_low      = n_seen_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= tsd_pkg::MODE_BT;
            r_pending   <= tsd_pkg::MODE_BT;
            r_run       <= '0;
            r_primed    <= 1'b0;
            r_seen_high <= 1'b0;
            r_seen_low  <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (i_advance) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_committed <= n_committed;
                r_pending   <= n_pending;
                r_run       <= n_run;
                r_primed    <= n_primed;
                r_seen_high <= n_seen_high;
                r_seen_low  <= n_seen_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/three_level_switch_debouncer.sv]
// Three-level switch debouncer: top level with configuration registers.
//
// Input channel: one converter reading per beat (i_in_valid / o_in_stall,
// payload i_in_item). Negative readings count as zero. Every eighth good
// reading closes a batch; a failed reading drops the batch in progress.
// Output channel: one beat per completed batch (o_out_valid / i_out_stall,
// payload o_out_item) with reported mode, committed position, level in
// millivolts and the sticky high/low flags. Other readings give no beat.
// Throughput: one reading per cycle, except for the stall described below.
// The result beat passes the accumulator, multiply and debounce registers
// after the reading that closed its batch. While the receiver stalls a
// waiting result, readings keep being taken; only the reading that would
// close the next batch is stalled until the output register drains.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 usb threshold, 1 dongle threshold, 2 debounce count, 3 override);
// write only while no batch is in flight.
// Reset (synchronous, active low) empties the pipeline, clears the batch,
// debounce state and sticky flags, and restores the register defaults.
module three_level_switch_debouncer #(
    parameter int ADC_BITS = tsd_pkg::ADC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tsd_pkg::t_in                   i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tsd_pkg::t_out                  o_out_item,
    input  logic                           i_cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tsd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    localparam int SUM_W = ADC_BITS + tsd_pkg::BATCH_LOG2;

    tsd_pkg::t_cfg               r_cfg;
    logic                        w_blocked;
    logic                        w_advance;
    logic                        w_accept;
    logic                        w_last;
    logic                        w_a_valid;
    logic [SUM_W-1:0]            w_a_sum;
    logic                        w_b_valid;
    logic [tsd_pkg::LEVEL_W-1:0] w_b_level;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.usb_thr       <= tsd_pkg::USB_THR_RST;
            r_cfg.dongle_thr    <= tsd_pkg::DONGLE_THR_RST;
            r_cfg.deb_count     <= tsd_pkg::DEBOUNCE_RST;
            r_cfg.override_mode <= tsd_pkg::OVERRIDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsd_pkg::CFG_USB_THR: begin
                    r_cfg.usb_thr <= i_cfg_wdata;
                end
                tsd_pkg::CFG_DONGLE_THR: begin
                    r_cfg.dongle_thr <= i_cfg_wdata;
                end
                tsd_pkg::CFG_DEBOUNCE: begin
                    r_cfg.deb_count <= i_cfg_wdata[tsd_pkg::RUN_W-1:0];
                end
                tsd_pkg::CFG_OVERRIDE: begin
                    r_cfg.override_mode <= i_cfg_wdata[tsd_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline moves unless the output beat is held
    assign w_blocked  = o_out_valid && i_out_stall;
    assign w_advance  = !w_blocked;
    assign o_in_stall = w_blocked && w_last;
    assign w_accept   = i_in_valid && !o_in_stall;

    tsd_accum #(
        .ADC_BITS (ADC_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_item    (i_in_item),
        .i_advance (w_advance),
        .o_last    (w_last),
        .o_valid   (w_a_valid),
        .o_sum     (w_a_sum)
    );

    tsd_scale #(
        .ADC_BITS (ADC_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_valid   (w_a_valid),
        .i_sum     (w_a_sum),
        .o_valid   (w_b_valid),
        .o_level   (w_b_level)
    );

    tsd_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (w_advance),
        .i_valid   (w_b_valid),
        .i_level   (w_b_level),
        .o_valid   (o_out_valid),
        .o_item    (o_out_item)
    );

endmodule

[hdl/tsd_checker.sv]
// Port-level checks for the three-level switch debouncer, bound to the top.
module tsd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input tsd_pkg::t_out o_out_item
);

    // A held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output beat changed while stalled");

    // Input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no result held");

    // Modes are positions, never the follow code
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.reported_mode != tsd_pkg::MODE_FOLLOW &&
                        o_out_item.switch_mode != tsd_pkg::MODE_FOLLOW)
        else $error("mode out of range");

    // Level stays below full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.level_mv < tsd_pkg::FULL_SCALE_MV)
        else $error("level above full scale");

    // Every result has seen at least one batch side
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.seen_high || o_out_item.seen_low)
        else $error("no sticky flag on a result");

endmodule

bind three_level_switch_debouncer tsd_checker u_tsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

[tb/sv/three_level_switch_debouncer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the three-level switch debouncer.
module three_level_switch_debouncer_tb;
    import tsd_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 2000;   // covers the long receiver hold-off
    localparam int LONG_HOLD     = 300;
    localparam int MAX_WAIT      = 17;
    localparam int SHOWN_ERRORS  = 10;
    localparam int SAMPLE_MAX    = (1 << ADC_BITS_DEF) - 1;
    localparam int RAW_MIN       = -(1 << (RAW_W - 2));

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Predicted block state and register copy
    t_cfg              cfg_shadow;
    int unsigned       acc_sum;
    int                acc_count;
    logic [MODE_W-1:0] committed_pos;
    logic [MODE_W-1:0] candidate_pos;
    logic [RUN_W-1:0]  candidate_run;
    logic              have_first;
    logic              seen_high_q;
    logic              seen_low_q;
    t_out              expected_results[$];

    // Traffic shaping knobs
    int in_gap_max     = MAX_WAIT;
    int rx_wait_max    = MAX_WAIT;
    int rx_wait_left   = 0;
    int rx_hold_cycles = 0;
    int target_raw     = 0;

    int error_count  = 0;
    int result_count = 0;
    int idle_cycles  = 0;

    three_level_switch_debouncer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Batch accumulation, level conversion, debounce and sticky flags
    function automatic void predict_reading(input t_in item);
        int unsigned       level;
        logic [MODE_W-1:0] pos;
        t_out              res;
        if (item.read_failed) begin
            acc_sum   = 0;
            acc_count = 0;
            return;
        end
        // negative readings count as zero, over-range ones saturate
        if (item.raw_sample[RAW_W-1])
            acc_sum += 0;
        else if (int'(item.raw_sample) > SAMPLE_MAX)
            acc_sum += SAMPLE_MAX;
        else
            acc_sum += int'(item.raw_sample);
        acc_count++;
        if (acc_count < BATCH_SIZE)
            return;

        level     = ((acc_sum / BATCH_SIZE) * FULL_SCALE_MV) >> ADC_BITS_DEF;
        acc_sum   = 0;
        acc_count = 0;

        // dongle threshold wins even when the usb threshold sits above it
        if (level >= cfg_shadow.dongle_thr)
            pos = MODE_DONGLE;
        else if (level >= cfg_shadow.usb_thr)
            pos = MODE_USB;
        else
            pos = MODE_BT;

        if (!have_first) begin
            committed_pos = pos;
            have_first    = 1'b1;
        end else if (pos == committed_pos) begin
            candidate_run = '0;
        end else if (pos == candidate_pos) begin
            if (candidate_run < RUN_MAX)
                candidate_run = candidate_run + 1'b1;
            if (candidate_run >= cfg_shadow.deb_count) begin
                committed_pos = pos;
                candidate_run = '0;
            end
        end else begin
            candidate_pos = pos;
            candidate_run = RUN_W'(1);
        end

        if (level >= cfg_shadow.dongle_thr)
            seen_high_q = 1'b1;
        else
            seen_low_q = 1'b1;

        res.reported_mode = (cfg_shadow.override_mode != MODE_FOLLOW) ?
                            cfg_shadow.override_mode : committed_pos;
        res.switch_mode   = committed_pos;
        res.level_mv      = level[LEVEL_W-1:0];
        res.seen_high     = seen_high_q;
        res.seen_low      = seen_low_q;
        expected_results.push_back(res);
    endfunction

    // Compare one result beat with the oldest prediction
    function automatic void check_result(input t_out got);
        t_out want;
        if (expected_results.size() == 0) begin
            if (error_count < SHOWN_ERRORS)
                $display("unexpected result: mode %0d switch %0d level %0d high %0b low %0b",
                         got.reported_mode, got.switch_mode, got.level_mv,
                         got.seen_high, got.seen_low);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.reported_mode !== want.reported_mode || got.switch_mode !== want.switch_mode ||
            got.level_mv !== want.level_mv || got.seen_high !== want.seen_high ||
            got.seen_low !== want.seen_low) begin
            if (error_count < SHOWN_ERRORS)
                $display({"result %0d wrong: exp mode %0d sw %0d mv %0d hi %0b lo %0b,",
                          " got %0d %0d %0d %0b %0b"},
                         result_count, want.reported_mode, want.switch_mode, want.level_mv,
                         want.seen_high, want.seen_low, got.reported_mode, got.switch_mode,
                         got.level_mv, got.seen_high, got.seen_low);
            error_count++;
        end
        result_count++;
    endfunction

    function automatic int draw_wait(input int max_wait);
        return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
    endfunction

    // Smallest reading whose constant batch lands exactly on the given level
    function automatic int raw_for_mv(input int mv);
        int raw;
        raw = (mv * (SAMPLE_MAX + 1) + FULL_SCALE_MV - 1) / FULL_SCALE_MV;
        return (raw > SAMPLE_MAX) ? SAMPLE_MAX : raw;
    endfunction

    function automatic int pick_target();
        case ($urandom_range(0, 7))
            0: return raw_for_mv(int'(cfg_shadow.usb_thr));
            1: return raw_for_mv(int'(cfg_shadow.usb_thr)) - 1;
            2: return raw_for_mv(int'(cfg_shadow.dongle_thr));
            3: return raw_for_mv(int'(cfg_shadow.dongle_thr)) - 1;
            4: return -$urandom_range(0, -RAW_MIN);
            5: return SAMPLE_MAX;
            default: return $urandom_range(0, SAMPLE_MAX);
        endcase
    endfunction

    function automatic t_in noisy_reading(input int center, input int spread);
        t_in item;
        int  val;
        val = center + $urandom_range(0, 2 * spread) - spread;
        if (val < RAW_MIN)
            val = RAW_MIN;
        if (val > SAMPLE_MAX)
            val = SAMPLE_MAX;
        item.raw_sample  = RAW_W'(val);
        item.read_failed = 1'b0;
        // now and then any bit pattern at all
        if ($urandom_range(0, 39) == 0)
            item.raw_sample = RAW_W'($urandom);
        return item;
    endfunction

    function automatic t_in failed_reading();
        t_in item;
        item.raw_sample  = RAW_W'($urandom);
        item.read_failed = 1'b1;
        return item;
    endfunction

    // Offer one reading after a random gap; predict it once accepted
    task automatic send_reading(input t_in item);
        int gap;
        gap = draw_wait(in_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        predict_reading(item);
    endtask

    // Stop offering and let every predicted result arrive
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
    endtask

    // Close any open batch, drain, then rewrite all four registers
    task automatic apply_settings(input logic [LEVEL_W-1:0] usb_mv,
                                  input logic [LEVEL_W-1:0] dongle_mv,
                                  input logic [RUN_W-1:0]   run_len,
                                  input logic [MODE_W-1:0]  ovr);
        logic [CFG_DATA_W-1:0] deb_word;
        logic [CFG_DATA_W-1:0] ovr_word;
        // upper bits of the narrow registers carry junk
        deb_word = CFG_DATA_W'($urandom);
        deb_word[RUN_W-1:0] = run_len;
        ovr_word = CFG_DATA_W'($urandom);
        ovr_word[MODE_W-1:0] = ovr;
        if (acc_count != 0)
            send_reading(failed_reading());
        wait_drained();
        write_register(CFG_USB_THR, usb_mv);
        write_register(CFG_DONGLE_THR, dongle_mv);
        write_register(CFG_DEBOUNCE, deb_word);
        write_register(CFG_OVERRIDE, ovr_word);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_shadow.usb_thr       = usb_mv;
        cfg_shadow.dongle_thr    = dongle_mv;
        cfg_shadow.deb_count     = run_len;
        cfg_shadow.override_mode = ovr;
    endtask

    // Batches around a target level that holds or moves; some broken batches
    task automatic run_batches(input int n_batches, input int change_pct);
        int spread;
        int n_good;
        repeat (n_batches) begin
            if ($urandom_range(0, 99) < change_pct)
                target_raw = pick_target();
            spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) :
                                                   $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0) begin
                n_good = $urandom_range(0, BATCH_SIZE - 1);
                repeat (n_good) send_reading(noisy_reading(target_raw, spread));
                send_reading(failed_reading());
            end
            repeat (BATCH_SIZE) send_reading(noisy_reading(target_raw, spread));
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    // Reset defaults: field extremes, failed readings, negative readings
    task automatic test_directed_readings();
        t_in item;
        item.read_failed = 1'b0;
        // full scale: first batch commits straight away
        item.raw_sample = RAW_W'(SAMPLE_MAX);
        repeat (BATCH_SIZE) send_reading(item);
        // partial batch thrown away by a failed conversion
        item.raw_sample = RAW_W'(0);
        send_reading(item);
        item.raw_sample = RAW_W'(1);
        send_reading(item);
        item.raw_sample = RAW_W'(SAMPLE_MAX);
        send_reading(item);
        send_reading(failed_reading());
        // failure with no batch open
        send_reading(failed_reading());
        // negative, minus one, zero, one, mid and full-scale readings
        for (int k = 0; k < BATCH_SIZE; k++) begin
            case (k)
                0, 5: item.raw_sample = RAW_W'(RAW_MIN);
                1: item.raw_sample = RAW_W'(-1);
                2: item.raw_sample = RAW_W'(0);
                3: item.raw_sample = RAW_W'(1);
                4: item.raw_sample = RAW_W'(2048);
                6: item.raw_sample = RAW_W'(SAMPLE_MAX);
                default: item.raw_sample = RAW_W'(1234);
            endcase
            send_reading(item);
        end
    endtask

    // Usb threshold above the dongle threshold
    task automatic test_crossed_thresholds();
        apply_settings(12'd3000, 12'd1000, 4'd2, MODE_FOLLOW);
        run_batches(10, 60);
    endtask

    // Debounce count zero, one, the maximum and a short one
    task automatic test_debounce_lengths();
        apply_settings(USB_THR_RST, DONGLE_THR_RST, 4'd0, MODE_FOLLOW);
        run_batches(10, 40);
        apply_settings(USB_THR_RST, DONGLE_THR_RST, 4'd1, MODE_FOLLOW);
        run_batches(10, 40);
        apply_settings(USB_THR_RST, DONGLE_THR_RST, RUN_MAX, MODE_FOLLOW);
        run_batches(20, 5);
        apply_settings(USB_THR_RST, DONGLE_THR_RST, 4'd2, MODE_FOLLOW);
        run_batches(8, 30);
    endtask

    // Every override code, ending on follow-switch
    task automatic test_override_modes();
        logic [MODE_W-1:0] ovr;
        ovr = MODE_BT;
        repeat (4) begin
            apply_settings(LEVEL_W'($urandom_range(0, SAMPLE_MAX)),
                           LEVEL_W'($urandom_range(0, SAMPLE_MAX)),
                           DEBOUNCE_RST, ovr);
            run_batches(4, 50);
            ovr = ovr + 1'b1;
        end
    endtask

    // Receiver holds off while readings stream in back to back
    task automatic test_backpressure();
        in_gap_max     = 0;
        rx_wait_max    = 0;
        rx_hold_cycles = LONG_HOLD;
        run_batches(8, 30);
        wait_drained();
        in_gap_max  = MAX_WAIT;
        rx_wait_max = MAX_WAIT;
    endtask

    // Random traffic over several settings, extremes first
    task automatic test_random_traffic();
        logic [LEVEL_W-1:0] usb_mv;
        logic [LEVEL_W-1:0] dongle_mv;
        logic [RUN_W-1:0]   run_len;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    usb_mv    = '0;
                    dongle_mv = '0;
                    run_len   = '0;
                end
                1: begin
                    usb_mv    = '1;
                    dongle_mv = '1;
                    run_len   = RUN_MAX;
                end
                2: begin
                    usb_mv    = FULL_SCALE_MV - 12'd1;
                    dongle_mv = FULL_SCALE_MV - 12'd1;
                    run_len   = RUN_W'($urandom_range(0, RUN_MAX));
                end
                default: begin
                    usb_mv    = LEVEL_W'($urandom_range(0, SAMPLE_MAX));
                    dongle_mv = LEVEL_W'($urandom_range(0, SAMPLE_MAX));
                    run_len   = RUN_W'($urandom_range(0, RUN_MAX));
                end
            endcase
            apply_settings(usb_mv, dongle_mv, run_len, MODE_W'($urandom_range(0, 3)));
            in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
            rx_wait_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
            run_batches(8, 35);
        end
    endtask

    // Result sink: long hold-off first, else a drawn wait per beat
    initial begin : result_sink
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                i_out_stall <= 1'b1;
            end else if (o_out_valid && rx_wait_left > 0) begin
                rx_wait_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result(o_out_item);
            rx_wait_left = draw_wait(rx_wait_max);
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;

        cfg_shadow.usb_thr       = USB_THR_RST;
        cfg_shadow.dongle_thr    = DONGLE_THR_RST;
        cfg_shadow.deb_count     = DEBOUNCE_RST;
        cfg_shadow.override_mode = OVERRIDE_RST;
        acc_sum       = 0;
        acc_count     = 0;
        committed_pos = MODE_BT;
        candidate_pos = MODE_BT;
        candidate_run = '0;
        have_first    = 1'b0;
        seen_high_q   = 1'b0;
        seen_low_q    = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_readings();
        test_crossed_thresholds();
        test_debounce_lengths();
        test_override_modes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        error_count += expected_results.size();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[three_level_switch_debouncer.f]
hdl/tsd_pkg.sv
hdl/tsd_accum.sv
hdl/tsd_scale.sv
hdl/tsd_debounce.sv
hdl/three_level_switch_debouncer.sv
hdl/tsd_checker.sv
tb/sv/three_level_switch_debouncer_tb.sv
